/* design/gcpl_pkg.sv */
package gcpl_pkg;

    localparam int CH_N       = 3;   // red, green, blue
    localparam int CH_W       = 8;
    localparam int LIN_W      = 16;  // linear light, Q0.16
    localparam int COLOR_W    = CH_N * CH_W;
    localparam int PAIR_N     = 4;
    localparam int PAIR_W     = 2 * COLOR_W;
    localparam int PALETTE_N  = 2 * PAIR_N;
    localparam int IDX_W      = 3;   // palette slot
    localparam int COUNT_W    = 4;   // color count register
    localparam int MAX_COLORS = 8;
    localparam int INV_ADDR_W = 12;  // inverse gamma uses top 12 bits of linear value
    localparam int CFG_ADDR_W = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_COLOR_COUNT = CFG_ADDR_W'(0),
        REG_COLORS_01   = CFG_ADDR_W'(1),
        REG_COLORS_23   = CFG_ADDR_W'(2),
        REG_COLORS_45   = CFG_ADDR_W'(3),
        REG_COLORS_67   = CFG_ADDR_W'(4)
    } cfg_reg_t;

    typedef logic [CH_N-1:0][CH_W-1:0]         rgb_t;      // [0] red, [1] green, [2] blue
    typedef logic [CH_N-1:0][LIN_W-1:0]        lin_rgb_t;
    typedef logic [PALETTE_N-1:0][COLOR_W-1:0] palette_t;
    typedef logic [255:0][LIN_W-1:0]           gam_tab_t;

    // count already clamped to 1..MAX_COLORS
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        palette_t           palette;
    } pal_cfg_t;

    // G[v] = floor(v*v*R[v] / 65025), R[v] = fifth root of v/255 in Q0.16 (floored)
    function automatic gam_tab_t build_gam_tab();
        gam_tab_t    tab;
        logic [95:0] lim;
        logic [95:0] pw;
        logic [15:0] q;
        logic [15:0] cand;
        tab = '0;
        for (int v = 0; v < 256; v++)
        begin
            lim = 96'(v) << 80;
            q   = '0;
            for (int b = 15; b >= 0; b--)
            begin
                cand = q | (16'(1) << b);
                pw   = 96'(cand) * 96'(cand);
                pw   = pw * 96'(cand);
                pw   = pw * 96'(cand);
                pw   = pw * 96'(cand);
                pw   = pw * 96'(255);
                if (pw <= lim)
                begin
                    q = cand;
                end
            end
            tab[v] = LIN_W'((96'(v) * 96'(v) * 96'(q)) / 96'(65025));
        end
        return tab;
    endfunction

    localparam gam_tab_t GAM_TAB = build_gam_tab();

endpackage

/* design/gcpl_mod.sv */
module gcpl_mod #(
    parameter int INDEX_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [INDEX_BITS-1:0]        whole,
    input  logic [FRAC_BITS-1:0]         frac,
    input  logic [gcpl_pkg::COUNT_W-1:0] count,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [gcpl_pkg::IDX_W-1:0]   key,
    output logic [FRAC_BITS-1:0]         key_frac
);
    import gcpl_pkg::*;

    // restoring remainder, 8 index bits per stage, MSB first
    localparam int STEP_BITS = 8;
    localparam int STAGES    = (INDEX_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_W     = STAGES * STEP_BITS;

    logic                 valid_reg [STAGES];
    logic [PAD_W-1:0]     whole_reg [STAGES];
    logic [IDX_W-1:0]     rem_reg   [STAGES];
    logic [FRAC_BITS-1:0] frac_reg  [STAGES];
    logic [STAGES:0]      go;

    function automatic logic [IDX_W-1:0] mod_step(
        input logic [IDX_W-1:0]     r_in,
        input logic [STEP_BITS-1:0] bits,
        input logic [COUNT_W-1:0]   cnt
    );
        logic [IDX_W-1:0]   r;
        logic [COUNT_W-1:0] t;
        r = r_in;
        for (int i = STEP_BITS - 1; i >= 0; i--)
        begin
            t = COUNT_W'({r, bits[i]});
            if (t >= cnt)
            begin
                t = t - cnt;
            end
            r = t[IDX_W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        go[STAGES] = out_ready;
        for (int s = STAGES - 1; s >= 0; s--)
        begin
            go[s] = !valid_reg[s] || go[s+1];
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic                 valid_src;
        logic [PAD_W-1:0]     whole_src;
        logic [IDX_W-1:0]     rem_src;
        logic [FRAC_BITS-1:0] frac_src;
        logic [IDX_W-1:0]     rem_next;

        if (s == 0)
        begin : g_first
            assign valid_src = in_valid;
            assign whole_src = PAD_W'(whole);
            assign rem_src   = '0;
            assign frac_src  = frac;
        end
        else
        begin : g_rest
            assign valid_src = valid_reg[s-1];
            assign whole_src = whole_reg[s-1];
            assign rem_src   = rem_reg[s-1];
            assign frac_src  = frac_reg[s-1];
        end

        assign rem_next = mod_step(rem_src, whole_src[PAD_W-1-s*STEP_BITS -: STEP_BITS], count);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (go[s])
            begin
                valid_reg[s] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (go[s])
            begin
                whole_reg[s] <= whole_src;
                rem_reg[s]   <= rem_next;
                frac_reg[s]  <= frac_src;
            end
        end
    end

    assign in_ready  = go[0];
    assign out_valid = valid_reg[STAGES-1];
    assign key       = rem_reg[STAGES-1];
    assign key_frac  = frac_reg[STAGES-1];

    // remainder must land inside the active palette
    a_key_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (COUNT_W'(key) < count))
        else $error("palette key not below color count");

endmodule

/* design/gcpl_mix.sv */
module gcpl_mix #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  gcpl_pkg::pal_cfg_t         cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [gcpl_pkg::IDX_W-1:0] key,
    input  logic [FRAC_BITS-1:0]       frac,
    output logic                       out_valid,
    input  logic                       out_ready,
    output gcpl_pkg::lin_rgb_t         lin
);
    import gcpl_pkg::*;

    localparam int PROD_W = LIN_W + 1 + FRAC_BITS + 1;

    // stage A: palette fetch + gamma table
    logic                 a_valid_reg;
    lin_rgb_t             a_la_reg;
    lin_rgb_t             a_lb_reg;
    logic [FRAC_BITS-1:0] a_frac_reg;
    lin_rgb_t             la_next;
    lin_rgb_t             lb_next;
    logic [COUNT_W-1:0]   key_inc;
    logic [IDX_W-1:0]     key_b;
    logic [COLOR_W-1:0]   color_a;
    logic [COLOR_W-1:0]   color_b;

    // stage B: (lb - la) * frac
    logic                     b_valid_reg;
    lin_rgb_t                 b_la_reg;
    logic signed [PROD_W-1:0] b_prod_reg [CH_N];
    logic signed [PROD_W-1:0] prod_next  [CH_N];

    // stage C: la + product >> FRAC_BITS
    logic     c_valid_reg;
    lin_rgb_t c_lin_reg;
    lin_rgb_t lin_next;

    logic go_a;
    logic go_b;
    logic go_c;

    assign go_c     = !c_valid_reg || out_ready;
    assign go_b     = !b_valid_reg || go_c;
    assign go_a     = !a_valid_reg || go_b;
    assign in_ready = go_a;

    always_comb
    begin
        key_inc = COUNT_W'(key) + COUNT_W'(1);
        if (key_inc == cfg.count)
        begin
            key_b = '0;
        end
        else
        begin
            key_b = key_inc[IDX_W-1:0];
        end
        color_a = cfg.palette[key];
        color_b = cfg.palette[key_b];
        for (int c = 0; c < CH_N; c++)
        begin
            la_next[c] = GAM_TAB[color_a[COLOR_W-1-c*CH_W -: CH_W]];
            lb_next[c] = GAM_TAB[color_b[COLOR_W-1-c*CH_W -: CH_W]];
        end
    end

    always_comb
    begin
        logic signed [LIN_W:0]     diff;
        logic signed [FRAC_BITS:0] frac_s;
        frac_s = $signed({1'b0, a_frac_reg});
        for (int c = 0; c < CH_N; c++)
        begin
            diff         = $signed({1'b0, a_lb_reg[c]}) - $signed({1'b0, a_la_reg[c]});
            prod_next[c] = diff * frac_s;
        end
    end

    // result is known to stay in 0..65535, so 16-bit wraparound is exact
    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            lin_next[c] = b_la_reg[c] + LIN_W'(b_prod_reg[c] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (go_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (go_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (go_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go_a)
        begin
            a_la_reg   <= la_next;
            a_lb_reg   <= lb_next;
            a_frac_reg <= frac;
        end
        if (go_b)
        begin
            b_la_reg <= a_la_reg;
            for (int c = 0; c < CH_N; c++)
            begin
                b_prod_reg[c] <= prod_next[c];
            end
        end
        if (go_c)
        begin
            c_lin_reg <= lin_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign lin       = c_lin_reg;

endmodule

/* design/gcpl_inv.sv */
module gcpl_inv (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  gcpl_pkg::lin_rgb_t lin,
    output logic               out_valid,
    input  logic               out_ready,
    output gcpl_pkg::rgb_t     rgb
);
    import gcpl_pkg::*;

    // largest v with G[v] <= 16*n, one result bit per stage, MSB first
    localparam int STEPS  = CH_W;
    localparam int ZERO_W = LIN_W - INV_ADDR_W;

    typedef logic [CH_N-1:0][INV_ADDR_W-1:0] tgt_t;

    logic            valid_reg [STEPS];
    rgb_t            v_reg     [STEPS];
    tgt_t            tgt_reg   [STEPS];
    logic [STEPS:0]  go;
    logic            search_ok;

    always_comb
    begin
        go[STEPS] = out_ready;
        for (int s = STEPS - 1; s >= 0; s--)
        begin
            go[s] = !valid_reg[s] || go[s+1];
        end
    end

    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        localparam logic [CH_W-1:0] BIT_MASK = CH_W'(1) << (CH_W - 1 - s);

        logic valid_src;
        rgb_t v_src;
        tgt_t tgt_src;
        rgb_t v_next;

        if (s == 0)
        begin : g_first
            assign valid_src = in_valid;
            assign v_src     = '0;
            always_comb
            begin
                for (int c = 0; c < CH_N; c++)
                begin
                    tgt_src[c] = lin[c][LIN_W-1 -: INV_ADDR_W];
                end
            end
        end
        else
        begin : g_rest
            assign valid_src = valid_reg[s-1];
            assign v_src     = v_reg[s-1];
            assign tgt_src   = tgt_reg[s-1];
        end

        always_comb
        begin
            for (int c = 0; c < CH_N; c++)
            begin
                if (GAM_TAB[v_src[c] | BIT_MASK] <= {tgt_src[c], {ZERO_W{1'b0}}})
                begin
                    v_next[c] = v_src[c] | BIT_MASK;
                end
                else
                begin
                    v_next[c] = v_src[c];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (go[s])
            begin
                valid_reg[s] <= valid_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (go[s])
            begin
                v_reg[s]   <= v_next;
                tgt_reg[s] <= tgt_src;
            end
        end
    end

    assign in_ready  = go[0];
    assign out_valid = valid_reg[STEPS-1];
    assign rgb       = v_reg[STEPS-1];

    // finished search: G[v] fits the target and G[v+1] does not
    always_comb
    begin
        logic [LIN_W-1:0] thr;
        search_ok = 1'b1;
        for (int c = 0; c < CH_N; c++)
        begin
            thr = {tgt_reg[STEPS-1][c], {ZERO_W{1'b0}}};
            if (GAM_TAB[rgb[c]] > thr)
            begin
                search_ok = 1'b0;
            end
            if ((rgb[c] != {CH_W{1'b1}}) && (GAM_TAB[rgb[c] + CH_W'(1)] <= thr))
            begin
                search_ok = 1'b0;
            end
        end
    end

    a_search_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> search_ok)
        else $error("inverse gamma search not at the largest fitting code");

endmodule

/* design/gamma_correct_palette_lerp.sv */
// Gamma-correct palette interpolation, one pixel per word.
//
// Index channel (idx_valid/idx_ready): index_whole picks palette color
// k = index_whole mod color_count and its successor (wrapping to color 0);
// index_frac is the Q0.FRAC_BITS blend weight toward the successor.
// Pixel channel (pix_valid/pix_ready): red, green, blue in sRGB, 8 bits each.
// Config port: cfg_write with cfg_addr/cfg_wdata updates one register in that
// cycle (0 color_count, 1..4 color pairs, even color in the low 24 bits).
// Write config only while no word is in flight.
//
// Throughput: one word per cycle unless pix_ready back-pressure fills the pipe; no stall of its own.
// Pipeline: ceil(INDEX_BITS/8) + 3 + 8 register stages (15 with defaults):
// the count modulo runs 8 index bits per stage, then palette fetch + gamma
// table, blend multiply, blend add, then the inverse gamma is a bit-per-stage
// search over the 256-entry gamma table.
// Each stage holds its word until the next one frees up, so a stalled
// pix_ready fills the pipe bubble by bubble before idx_ready drops; nothing
// is lost or repeated. Reset empties the pipe, sets color_count to 1 and all
// palette colors to black.
module gamma_correct_palette_lerp #(
    parameter int INDEX_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            idx_valid,
    output logic                            idx_ready,
    input  logic [INDEX_BITS-1:0]           index_whole,
    input  logic [FRAC_BITS-1:0]            index_frac,
    output logic                            pix_valid,
    input  logic                            pix_ready,
    output logic [gcpl_pkg::CH_W-1:0]       red,
    output logic [gcpl_pkg::CH_W-1:0]       green,
    output logic [gcpl_pkg::CH_W-1:0]       blue,
    input  logic                            cfg_write,
    input  logic [gcpl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gcpl_pkg::PAIR_W-1:0]     cfg_wdata
);
    import gcpl_pkg::*;

    // config registers
    logic [COUNT_W-1:0]           color_count_reg;
    logic [PAIR_N-1:0][PAIR_W-1:0] pair_reg;
    pal_cfg_t                     cfg;

    // modulo -> mix
    logic                 key_valid;
    logic                 key_ready;
    logic [IDX_W-1:0]     key;
    logic [FRAC_BITS-1:0] key_frac;

    // mix -> inverse gamma
    logic     lin_valid;
    logic     lin_ready;
    lin_rgb_t lin;

    rgb_t pix_rgb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_count_reg <= COUNT_W'(1);
            pair_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_addr)
                REG_COLOR_COUNT: color_count_reg <= cfg_wdata[COUNT_W-1:0];
                REG_COLORS_01:   pair_reg[0]     <= cfg_wdata;
                REG_COLORS_23:   pair_reg[1]     <= cfg_wdata;
                REG_COLORS_45:   pair_reg[2]     <= cfg_wdata;
                REG_COLORS_67:   pair_reg[3]     <= cfg_wdata;
                default:         ;  // unmapped index, write dropped
            endcase
        end
    end

    // zero count acts as one, oversize count clamps to the palette size
    always_comb
    begin
        priority if (color_count_reg == '0)
        begin
            cfg.count = COUNT_W'(1);
        end
        else if (color_count_reg > COUNT_W'(MAX_COLORS))
        begin
            cfg.count = COUNT_W'(MAX_COLORS);
        end
        else
        begin
            cfg.count = color_count_reg;
        end
        for (int p = 0; p < PAIR_N; p++)
        begin
            cfg.palette[2*p]   = pair_reg[p][COLOR_W-1:0];
            cfg.palette[2*p+1] = pair_reg[p][PAIR_W-1:COLOR_W];
        end
    end

    gcpl_mod #(
        .INDEX_BITS (INDEX_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (idx_valid),
        .in_ready  (idx_ready),
        .whole     (index_whole),
        .frac      (index_frac),
        .count     (cfg.count),
        .out_valid (key_valid),
        .out_ready (key_ready),
        .key       (key),
        .key_frac  (key_frac)
    );

    gcpl_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (key_valid),
        .in_ready  (key_ready),
        .key       (key),
        .frac      (key_frac),
        .out_valid (lin_valid),
        .out_ready (lin_ready),
        .lin       (lin)
    );

    gcpl_inv u_inv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lin_valid),
        .in_ready  (lin_ready),
        .lin       (lin),
        .out_valid (pix_valid),
        .out_ready (pix_ready),
        .rgb       (pix_rgb)
    );

    assign red   = pix_rgb[0];
    assign green = pix_rgb[1];
    assign blue  = pix_rgb[2];

    a_count_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.count != '0) && (cfg.count <= COUNT_W'(MAX_COLORS)))
        else $error("effective color count out of range");

    // an empty output stage means every stage can move, so the index side is open
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_valid |-> idx_ready)
        else $error("index side blocked with empty output stage");

endmodule
